/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; they compile to nothing when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

/* hw/rtl/spls_pkg.sv */
// ---------------------------------------------------------------------------
// spls_pkg
// Widths, codes and the sequencer microprogram of the path length search.
// ---------------------------------------------------------------------------
package spls_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VertW       = 4;
  localparam int unsigned CntW        = 5;
  localparam int unsigned LenW        = 4;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned TopW        = $clog2(MaxVertices);
  localparam int unsigned DepthW      = TopW + 1;
  localparam int unsigned NextW       = VertW + 1;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CntW-1:0] VertexCountReset = 5'd16;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_e;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_FETCH = 3'd2,
    ST_SCAN  = 3'd3,
    ST_STEP  = 3'd4,
    ST_POP   = 3'd5,
    ST_DONE  = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    ACT_ACCEPT  = 3'd0,
    ACT_INIT    = 3'd1,
    ACT_FETCH   = 3'd2,
    ACT_SCAN    = 3'd3,
    ACT_ADVANCE = 3'd4,
    ACT_POP     = 3'd5,
    ACT_RESULT  = 3'd6
  } act_e;

  typedef enum logic [2:0] {
    COND_QUERY    = 3'd0,
    COND_SHORT    = 3'd1,
    COND_ALWAYS   = 3'd2,
    COND_HIT      = 3'd3,
    COND_FOUND    = 3'd4,
    COND_BOTTOM   = 3'd5,
    COND_OUT_FREE = 3'd6
  } cond_e;

  // one control word: action, branch condition, target when taken, else next
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e jump;
    step_e next;
  } ctrl_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t cw;
    case (step)
      ST_IDLE:  cw = '{act: ACT_ACCEPT,  cond: COND_QUERY,    jump: ST_CHECK, next: ST_IDLE};
      ST_CHECK: cw = '{act: ACT_INIT,    cond: COND_SHORT,    jump: ST_DONE,  next: ST_FETCH};
      ST_FETCH: cw = '{act: ACT_FETCH,   cond: COND_ALWAYS,   jump: ST_SCAN,  next: ST_SCAN};
      ST_SCAN:  cw = '{act: ACT_SCAN,    cond: COND_HIT,      jump: ST_STEP,  next: ST_POP};
      ST_STEP:  cw = '{act: ACT_ADVANCE, cond: COND_FOUND,    jump: ST_DONE,  next: ST_FETCH};
      ST_POP:   cw = '{act: ACT_POP,     cond: COND_BOTTOM,   jump: ST_DONE,  next: ST_FETCH};
      ST_DONE:  cw = '{act: ACT_RESULT,  cond: COND_OUT_FREE, jump: ST_IDLE,  next: ST_DONE};
      default:  cw = '{act: ACT_ACCEPT,  cond: COND_QUERY,    jump: ST_CHECK, next: ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

/* hw/rtl/spls_if.sv */
// ---------------------------------------------------------------------------
// spls_req_if / spls_rsp_if
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface spls_req_if import spls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [VertW-1:0] first_vertex;
  logic [VertW-1:0] second_vertex;
  logic [LenW-1:0]  path_length;

  modport source (output valid, command, first_vertex, second_vertex, path_length,
                  input ready);
  modport sink   (input valid, command, first_vertex, second_vertex, path_length,
                  output ready);
endinterface

interface spls_rsp_if import spls_pkg::*; ();
  logic valid;
  logic ready;
  logic path_found;
  logic bad_request;

  modport source (output valid, path_found, bad_request, input ready);
  modport sink   (input valid, path_found, bad_request, output ready);
endinterface

/* hw/rtl/simple_path_length_search.sv */
// ---------------------------------------------------------------------------
// simple_path_length_search
// Adjacency matrix of an undirected graph plus a microcoded depth-first
// search that answers whether a simple path of path_length edges joins two
// vertices.
// ---------------------------------------------------------------------------
//   channel  dir  handshake       word
//   req_i    in   valid/ready     command, first_vertex, second_vertex, path_length
//   rsp_o    out  valid/ready     path_found, bad_request
//   cfg      in   APB write/read  vertex_count at byte address 0
//
// Clear and add-edge words give no result.
// A query sets up in the check step and, unless bad or zero-length, makes search
// moves (fetch top of stack, scan the neighbor row, push/advance or pop); it posts
// the result in the done step. The sequencer walks one search move at a time.
// Reset clears the matrix at once: no sweep, words are taken right after reset.
// A result held in the output register stalls the next query in its result
// step, and no word is taken until that result posts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module simple_path_length_search import spls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  spls_req_if.sink            req_i,
  spls_rsp_if.source          rsp_o
);

  step_e                  upc_q, upc_d;
  ctrl_t                  cw;
  logic                   cond_met;

  logic [CntW-1:0]        vcount_q;
  logic [CntW-1:0]        count_eff;
  logic [MaxVertices-1:0] adj_q [MaxVertices];
  logic [MaxVertices-1:0] visited_q;
  logic [VertW-1:0]       stk_vtx_q [MaxVertices];
  logic [NextW-1:0]       stk_nxt_q [MaxVertices];
  logic [DepthW-1:0]      depth_q;
  logic [TopW-1:0]        top, top_up;

  logic [VertW-1:0]       start_q, target_q, v_q;
  logic [LenW-1:0]        len_q;
  logic [NextW-1:0]       u_q;
  logic                   bad_q, found_q;
  logic                   rsp_valid_q, rsp_found_q, rsp_bad_q;

  logic                   req_fire, cfg_we, in_range, bad_c;
  logic                   is_target, found_c, push_c, out_free, load_rsp;
  logic [MaxVertices-1:0] row, cand;
  logic                   hit;
  logic [VertW-1:0]       first;

  assign cw       = ucode(upc_q);
  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_VERTEX_COUNT) ? CfgDataW'(vcount_q) : '0;

  assign count_eff = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;
  assign in_range  = (CntW'(req_i.first_vertex) < count_eff) &&
                     (CntW'(req_i.second_vertex) < count_eff);
  assign bad_c     = !((CntW'(start_q) < count_eff) && (CntW'(target_q) < count_eff));

  assign req_i.ready = (cw.act == ACT_ACCEPT);

  assign top    = depth_q[TopW-1:0];
  assign top_up = top + TopW'(1);

  // next unvisited in-range neighbor of v at or after u
  always_comb begin
    row   = adj_q[v_q];
    first = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      cand[i] = row[i] && !visited_q[i] && (CntW'(i) < count_eff) && (NextW'(i) >= u_q);
    end
    hit = |cand;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (cand[i]) first = VertW'(i);
    end
  end

  assign is_target = (u_q == NextW'(target_q));
  assign found_c   = is_target && ((depth_q + DepthW'(1)) == DepthW'(len_q));
  assign push_c    = !is_target && ((depth_q + DepthW'(1)) < DepthW'(len_q)) &&
                     ((depth_q + DepthW'(1)) < DepthW'(MaxVertices));
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign load_rsp  = (cw.act == ACT_RESULT) && out_free;

  always_comb begin
    case (cw.cond)
      COND_QUERY:    cond_met = req_fire && (req_i.command == CMD_QUERY);
      COND_SHORT:    cond_met = bad_c || (len_q == '0);
      COND_ALWAYS:   cond_met = 1'b1;
      COND_HIT:      cond_met = hit;
      COND_FOUND:    cond_met = found_c;
      COND_BOTTOM:   cond_met = (depth_q == '0);
      COND_OUT_FREE: cond_met = out_free;
      default:       cond_met = 1'b0;
    endcase
    upc_d = cond_met ? cw.jump : cw.next;
  end

  // control state, graph and search marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_IDLE;
      vcount_q    <= VertexCountReset;
      visited_q   <= '0;
      depth_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int r = 0; r < MaxVertices; r++) begin
        adj_q[r] <= '0;
      end
    end else begin
      upc_q <= upc_d;
      if (cfg_we && (paddr[2] == REG_VERTEX_COUNT)) begin
        vcount_q <= pwdata[CntW-1:0];
      end
      if (req_fire) begin
        case (req_i.command)
          CMD_CLEAR: begin
            for (int r = 0; r < MaxVertices; r++) begin
              adj_q[r] <= '0;
            end
          end
          CMD_ADD: begin
            if (in_range) begin
              adj_q[req_i.first_vertex][req_i.second_vertex] <= 1'b1;
              adj_q[req_i.second_vertex][req_i.first_vertex] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      case (cw.act)
        ACT_INIT: begin
          visited_q <= {{(MaxVertices-1){1'b0}}, 1'b1} << start_q;
          depth_q   <= '0;
        end
        ACT_ADVANCE: begin
          if (push_c) begin
            depth_q                   <= depth_q + DepthW'(1);
            visited_q[u_q[VertW-1:0]] <= 1'b1;
          end
        end
        ACT_POP: begin
          visited_q[v_q] <= 1'b0;
          if (depth_q != '0) depth_q <= depth_q - DepthW'(1);
        end
        ACT_RESULT: begin
          if (out_free) begin
            visited_q <= '0;
            depth_q   <= '0;
          end
        end
        default: ;
      endcase
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath payload: query word, stack, scan pointers, result word
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      start_q  <= req_i.first_vertex;
      target_q <= req_i.second_vertex;
      len_q    <= req_i.path_length;
    end
    case (cw.act)
      ACT_INIT: begin
        stk_vtx_q[0] <= start_q;
        stk_nxt_q[0] <= '0;
        bad_q        <= bad_c;
        found_q      <= !bad_c && (len_q == '0) && (start_q == target_q);
      end
      ACT_FETCH: begin
        v_q <= stk_vtx_q[top];
        u_q <= stk_nxt_q[top];
      end
      ACT_SCAN: u_q <= NextW'(first);
      ACT_ADVANCE: begin
        stk_nxt_q[top] <= u_q + NextW'(1);
        if (push_c) begin
          stk_vtx_q[top_up] <= u_q[VertW-1:0];
          stk_nxt_q[top_up] <= '0;
        end
        if (found_c) found_q <= 1'b1;
      end
      default: ;
    endcase
    if (load_rsp) begin
      rsp_found_q <= found_q;
      rsp_bad_q   <= bad_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.path_found  = rsp_found_q;
  assign rsp_o.bad_request = rsp_bad_q;

  `ASSERT_CLK(a_idle_clean, clk_i, rst_ni,
    (upc_q == ST_IDLE) |-> (visited_q == '0 && depth_q == '0),
    "search marks left set while idle")
  `ASSERT_CLK(a_depth_below_len, clk_i, rst_ni,
    (upc_q == ST_FETCH) |-> (depth_q < DepthW'(len_q)),
    "stack depth reached the path length")
  `ASSERT_CLK(a_start_visited, clk_i, rst_ni,
    (upc_q == ST_FETCH) |-> visited_q[start_q],
    "start vertex lost its mark during search")
  `ASSERT_CLK(a_rsp_from_done, clk_i, rst_ni,
    $rose(rsp_valid_q) |-> $past(upc_q == ST_DONE),
    "result word loaded outside the result step")
  `ASSERT_NEVER(a_found_and_bad, clk_i, rst_ni,
    rsp_valid_q && rsp_found_q && rsp_bad_q,
    "result word flags both found and bad request")

endmodule
